// File: rtl/core/qtt_pkg.sv
`default_nettype none

package qtt_pkg;

  // field widths fixed by the interface
  localparam int KIND_W    = 2;
  localparam int OP_W      = 2;
  localparam int TID_W     = 16;
  localparam int NOW_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int CNT_W     = 2;
  localparam int QUORUM_W  = 2;
  localparam int TIMEOUT_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_QUORUM  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;
  localparam logic [QUORUM_W-1:0]  QUORUM_RESET  = 2'd2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd5;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OPENED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SUCCESS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAIL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

  // sweep result limit
  localparam int MAX_RESULTS = 16;
  localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

  // slot index reduction for non power of two slot counts
  localparam int RED_BITS   = 4;
  localparam int RED_STEPS  = TID_W / RED_BITS;
  localparam int RED_CNT_W  = $clog2(RED_STEPS + 1);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OP_W-1:0]   op;
    logic [TID_W-1:0]  tid;
    logic              ok;
    logic [NOW_W-1:0]  now;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    id;
    logic [OP_W-1:0]     op;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [TID_W-1:0] number;
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] ok_cnt;
    logic [CNT_W-1:0] fail_cnt;
    logic [NOW_W-1:0] started;
  } entry_t;

  typedef struct packed {
    logic [QUORUM_W-1:0]  quorum;
    logic [TIMEOUT_W-1:0] timeout;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_REPLY,
    B_SW_RD,
    B_SW_EV,
    B_SW_END
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/quorum_transaction_tracker.sv
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-------------------------------------------
// in       | input     | in_valid/in_ready   | kind, op_type, trans_id, reply_ok, now
// out      | output    | out_valid/out_ready | status, result_id, result_op, last
// cfg      | input     | cfg_we, no wait     | cfg_index selects quorum or timeout
//
// an open result passes the front register and the queue and is written to the back's result
// register; a reply is a slot memory read then its write-back or its result, after the front's
// remainder reduction when SLOTS is not a power of two; a sweep is the pop, one memory read and
// one check per slot up to the last slot or MAX_RESULTS timeouts, and a closing state
// the front takes a new item in the same cycle it hands one to the queue
// synchronous active-low reset; slot contents are not cleared, only the valid bits
// a full result register stalls the back, a full queue stalls the front and in_ready
`default_nettype none

module quorum_transaction_tracker
  import qtt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic [OP_W-1:0]       in_op_type,
  input  wire logic [TID_W-1:0]      in_trans_id,
  input  wire logic                  in_reply_ok,
  input  wire logic [NOW_W-1:0]      in_now,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [TID_W-1:0]           out_result_id,
  output logic [OP_W-1:0]            out_result_op,
  output logic                       out_last,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(SLOTS);

  // configuration registers
  cfg_t cfg_r;

  // front to queue
  logic             f_push_valid;
  logic             f_push_ready;
  cmd_t             f_cmd;
  logic [IDX_W-1:0] f_slot;

  // queue to back
  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;
  logic [IDX_W-1:0] q_slot;

  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quorum  <= QUORUM_RESET;
      cfg_r.timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUORUM:  cfg_r.quorum  <= cfg_data[QUORUM_W-1:0];
        CFG_TIMEOUT: cfg_r.timeout <= cfg_data[TIMEOUT_W-1:0];
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  // front: takes each transfer, drops the unused kind, works out the reply slot
  qtt_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_op_type  (in_op_type),
    .in_trans_id (in_trans_id),
    .in_reply_ok (in_reply_ok),
    .in_now      (in_now),
    .push_valid  (f_push_valid),
    .push_ready  (f_push_ready),
    .push_cmd    (f_cmd),
    .push_slot   (f_slot)
  );

  // short command queue so front and back stall independently
  qtt_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push_valid),
    .push_ready (f_push_ready),
    .push_cmd   (f_cmd),
    .push_slot  (f_slot),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd),
    .pop_slot   (q_slot)
  );

  // back: slot table, numbering, quorum counting, sweep walk and result register
  qtt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .q_slot    (q_slot),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_status    = res.status;
  assign out_result_id = res.id;
  assign out_result_op = res.op;
  assign out_last      = res.last;

`ifndef ASSERT_OFF
  // the back only pops a command that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back popped an empty queue");

  // only sweep results can be followed by more results of the same request
  a_not_last_is_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_TIMEOUT))
    else $error("non-final result that is not a timeout");

  // nothing is offered in the first cycle after reset is released
  a_reset_quiet: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// File: rtl/core/qtt_ram.sv
`default_nettype none

module qtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/qtt_front.sv
`default_nettype none

module qtt_front
  import qtt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [KIND_W-1:0]        in_kind,
  input  wire logic [OP_W-1:0]          in_op_type,
  input  wire logic [TID_W-1:0]         in_trans_id,
  input  wire logic                     in_reply_ok,
  input  wire logic [NOW_W-1:0]         in_now,
  output logic                          push_valid,
  input  wire logic                     push_ready,
  output cmd_t                          push_cmd,
  output logic [$clog2(SLOTS)-1:0]      push_slot
);

  localparam int  IDX_W = $clog2(SLOTS);
  localparam bit  POW2  = (SLOTS & (SLOTS - 1)) == 0;

  logic             hold_v_r;
  cmd_t             hold_r;
  logic             done;
  logic [IDX_W-1:0] slot;
  logic             accept;
  logic             load;
  logic             push;

  assign push       = hold_v_r && done && push_ready;
  assign in_ready   = !hold_v_r || push;
  assign accept     = in_valid && in_ready;
  // unused request code is dropped here
  assign load       = accept && (in_kind != KIND_NONE);
  assign push_valid = hold_v_r && done;
  assign push_cmd   = hold_r;
  assign push_slot  = slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (accept) begin
      hold_v_r <= load;
    end else if (push) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= '{kind: in_kind, op: in_op_type, tid: in_trans_id,
                  ok: in_reply_ok, now: in_now};
    end
  end

  generate
    if (POW2) begin : g_mask
      assign slot = hold_r.tid[IDX_W-1:0];
      assign done = 1'b1;
    end else begin : g_reduce
      // remainder by slot count, RED_BITS bits of the id per step
      logic [IDX_W-1:0]     rem_r;
      logic [IDX_W-1:0]     rem_nxt;
      logic [TID_W-1:0]     sh_r;
      logic [RED_CNT_W-1:0] cnt_r;

      always_comb begin
        logic [IDX_W:0]   t;
        logic [IDX_W-1:0] r;
        r = rem_r;
        t = '0;
        for (int i = 0; i < RED_BITS; i++) begin
          t = {r, sh_r[TID_W-1-i]};
          if (t >= (IDX_W+1)'(SLOTS)) begin
            t = t - (IDX_W+1)'(SLOTS);
          end
          r = t[IDX_W-1:0];
        end
        rem_nxt = r;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cnt_r <= RED_CNT_W'(RED_STEPS);
        end else if (load) begin
          cnt_r <= '0;
        end else if (cnt_r != RED_CNT_W'(RED_STEPS)) begin
          cnt_r <= cnt_r + RED_CNT_W'(1);
        end
      end

      always_ff @(posedge clk) begin
        if (load) begin
          rem_r <= '0;
          sh_r  <= in_trans_id;
        end else if (cnt_r != RED_CNT_W'(RED_STEPS)) begin
          rem_r <= rem_nxt;
          sh_r  <= sh_r << RED_BITS;
        end
      end

      assign slot = rem_r;
      assign done = (cnt_r == RED_CNT_W'(RED_STEPS)) || (hold_r.kind != KIND_REPLY);
    end
  endgenerate

endmodule

`default_nettype wire

// File: rtl/core/qtt_queue.sv
`default_nettype none

module qtt_queue
  import qtt_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire cmd_t             push_cmd,
  input  wire logic [IDX_W-1:0] push_slot,
  output logic                  pop_valid,
  input  wire logic             pop,
  output cmd_t                  pop_cmd,
  output logic [IDX_W-1:0]      pop_slot
);

  cmd_t             cmd_q  [QUEUE_DEPTH];
  logic [IDX_W-1:0] slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = cnt_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = cmd_q[rd_ptr_r];
  assign pop_slot   = slot_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_q[wr_ptr_r]  <= push_cmd;
      slot_q[wr_ptr_r] <= push_slot;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/qtt_back.sv
`default_nettype none

module qtt_back
  import qtt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     q_valid,
  output logic                          q_pop,
  input  wire cmd_t                     q_cmd,
  input  wire logic [$clog2(SLOTS)-1:0] q_slot,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output res_t                          res
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int ENTRY_W = $bits(entry_t);

  back_state_t      state_r, state_nxt;
  logic [TID_W-1:0] next_num_r, next_num_nxt;
  logic [IDX_W-1:0] cand_slot_r, cand_slot_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  cmd_t             cur_r, cur_nxt;
  logic [IDX_W-1:0] cur_slot_r, cur_slot_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [FOUND_W-1:0] found_r, found_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [TID_W-1:0] pend_id_r, pend_id_nxt;
  logic [OP_W-1:0]  pend_op_r, pend_op_nxt;
  logic             out_v_r, out_v_nxt;
  res_t             out_r, out_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_entry;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  entry_t           rd_entry;

  logic [TID_W-1:0]    cand_num;
  logic [QUORUM_W-1:0] q_eff;
  logic                out_free;
  logic                hit;
  logic [CNT_W-1:0]    ok_new;
  logic [CNT_W-1:0]    fail_new;
  logic                settle_ok;
  logic                settle_fail;
  logic [NOW_W-1:0]    age;
  logic                expired;
  logic                sw_stall;
  logic [FOUND_W-1:0]  found_inc;
  logic                sw_done;

  qtt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_entry),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_entry = entry_t'(ram_rd_data);

  // shared conditions
  always_comb begin
    cand_num    = next_num_r + TID_W'(1);
    q_eff       = (cfg.quorum == '0) ? QUORUM_W'(1) : cfg.quorum;
    out_free    = !out_v_r || res_ready;
    hit         = valid_r[cur_slot_r] && (rd_entry.number == cur_r.tid);
    ok_new      = rd_entry.ok_cnt;
    fail_new    = rd_entry.fail_cnt;
    if (cur_r.ok) begin
      if (rd_entry.ok_cnt != CNT_MAX) begin
        ok_new = rd_entry.ok_cnt + CNT_W'(1);
      end
    end else begin
      if (rd_entry.fail_cnt != CNT_MAX) begin
        fail_new = rd_entry.fail_cnt + CNT_W'(1);
      end
    end
    settle_ok   = ok_new >= q_eff;
    settle_fail = fail_new >= q_eff;
    age         = cur_r.now - rd_entry.started;
    expired     = valid_r[scan_r] && (age > NOW_W'(cfg.timeout));
    sw_stall    = expired && pend_v_r && !out_free;
    found_inc   = found_r + FOUND_W'(1);
    sw_done     = (expired && (found_inc == FOUND_W'(MAX_RESULTS)))
                  || (scan_r == IDX_W'(SLOTS - 1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            KIND_REPLY: state_nxt = B_REPLY;
            KIND_SWEEP: state_nxt = B_SW_RD;
            default:    state_nxt = B_IDLE;
          endcase
        end
      end
      B_REPLY: begin
        if (!hit || !(settle_ok || settle_fail) || out_free) begin
          state_nxt = B_IDLE;
        end
      end
      B_SW_RD: state_nxt = B_SW_EV;
      B_SW_EV: begin
        if (!sw_stall) begin
          state_nxt = sw_done ? B_SW_END : B_SW_RD;
        end
      end
      B_SW_END: begin
        if (!pend_v_r || out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // actions
  always_comb begin
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_wr_addr   = cand_slot_r;
    ram_wr_entry  = '{number: cand_num, op: q_cmd.op, ok_cnt: '0, fail_cnt: '0,
                      started: q_cmd.now};
    ram_rd_addr   = scan_r;
    next_num_nxt  = next_num_r;
    cand_slot_nxt = cand_slot_r;
    valid_nxt     = valid_r;
    cur_nxt       = cur_r;
    cur_slot_nxt  = cur_slot_r;
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    pend_op_nxt   = pend_op_r;
    out_v_nxt     = out_v_r && !res_ready;
    out_nxt       = out_r;

    unique case (state_r)
      B_IDLE: begin
        ram_rd_addr = q_slot;
        if (q_valid) begin
          unique case (q_cmd.kind)
            KIND_OPEN: begin
              if (out_free) begin
                q_pop     = 1'b1;
                out_v_nxt = 1'b1;
                if (valid_r[cand_slot_r]) begin
                  out_nxt = '{status: ST_FULL, id: cand_num, op: q_cmd.op, last: 1'b1};
                end else begin
                  out_nxt = '{status: ST_OPENED, id: cand_num, op: q_cmd.op, last: 1'b1};
                  ram_we  = 1'b1;
                  valid_nxt[cand_slot_r] = 1'b1;
                  next_num_nxt = cand_num;
                  if (cand_num == '1 || cand_slot_r == IDX_W'(SLOTS - 1)) begin
                    cand_slot_nxt = '0;
                  end else begin
                    cand_slot_nxt = cand_slot_r + IDX_W'(1);
                  end
                end
              end
            end
            KIND_REPLY: begin
              q_pop        = 1'b1;
              cur_nxt      = q_cmd;
              cur_slot_nxt = q_slot;
            end
            KIND_SWEEP: begin
              q_pop      = 1'b1;
              cur_nxt    = q_cmd;
              scan_nxt   = '0;
              found_nxt  = '0;
              pend_v_nxt = 1'b0;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      B_REPLY: begin
        ram_rd_addr  = cur_slot_r;
        ram_wr_addr  = cur_slot_r;
        ram_wr_entry = '{number: rd_entry.number, op: rd_entry.op, ok_cnt: ok_new,
                         fail_cnt: fail_new, started: rd_entry.started};
        if (hit) begin
          if (settle_ok || settle_fail) begin
            if (out_free) begin
              // success is checked before failure
              out_v_nxt = 1'b1;
              out_nxt   = '{status: settle_ok ? ST_SUCCESS : ST_FAIL,
                            id: cur_r.tid, op: rd_entry.op, last: 1'b1};
              valid_nxt[cur_slot_r] = 1'b0;
            end
          end else begin
            ram_we = 1'b1;
          end
        end
      end
      B_SW_RD: begin
        ram_rd_addr = scan_r;
      end
      B_SW_EV: begin
        ram_rd_addr = scan_r;
        if (!sw_stall) begin
          if (expired) begin
            if (pend_v_r) begin
              out_v_nxt = 1'b1;
              out_nxt   = '{status: ST_TIMEOUT, id: pend_id_r, op: pend_op_r, last: 1'b0};
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = rd_entry.number;
            pend_op_nxt = rd_entry.op;
            found_nxt   = found_inc;
            valid_nxt[scan_r] = 1'b0;
          end
          if (!sw_done) begin
            scan_nxt = scan_r + IDX_W'(1);
          end
        end
      end
      B_SW_END: begin
        if (pend_v_r && out_free) begin
          out_v_nxt  = 1'b1;
          out_nxt    = '{status: ST_TIMEOUT, id: pend_id_r, op: pend_op_r, last: 1'b1};
          pend_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      next_num_r  <= '0;
      cand_slot_r <= IDX_W'(1);
      valid_r     <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_num_r  <= next_num_nxt;
      cand_slot_r <= cand_slot_nxt;
      valid_r     <= valid_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    cur_slot_r <= cur_slot_nxt;
    scan_r     <= scan_nxt;
    found_r    <= found_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_op_r  <= pend_op_nxt;
    out_r      <= out_nxt;
  end

  assign res_valid = out_v_r;
  assign res       = out_r;

endmodule

`default_nettype wire
